/* design/spq_pkg.sv */
// Shared types and constants for the stable priority queue core.
// Used by spq_cell and stable_priority_queue_core; depends on nothing.
package spq_pkg;

  // Number of cells in the chain
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the stream items
  localparam int OUT_CNT_W = 5;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 144;

  // Action codes of an input item
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } spq_action_t;

  // Status codes of a result item
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } spq_status_t;

  // One stored entry
  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] value;
    logic [7:0]  zone;
    logic [15:0] id;
  } spq_entry_t;

  // Step command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } spq_ctl_t;

endpackage

/* design/stable_priority_queue_core.sv */
// The result item is registered and valid in the cycle after its input item.
// Throughput: one item per cycle unless out_tready stalls the result; every
// cell compares its priority with the new one in parallel and shifts by one
// place, so an insert, remove or clear finishes in a single step of the cell chain.
// Reset (synchronous, active low) clears the cell valid bits, the count and
// the result valid flag; entry payloads and result data are not reset.
module stable_priority_queue_core
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // action[1:0], task_id[17:2], zone[25:18], value_bits[57:26],
  // priority_req[65:58], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], removed_valid[2], removed_id[18:3], removed_zone[26:19],
  // removed_value[58:27], removed_priority[66:59], head_id[82:67],
  // head_zone[90:83], head_value[122:91], head_priority[130:123],
  // entry_count[135:131], is_empty[136], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  spq_action_t           action;
  spq_entry_t            new_entry;
  spq_ctl_t              ctl;
  logic                  in_fire;
  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  spq_status_t           status;
  spq_entry_t            removed;
  spq_entry_t            head;

  spq_entry_t            cell_entry [DEPTH];
  spq_entry_t            cell_entry_nxt [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_valid_nxt;
  logic [DEPTH-1:0]      cell_gt;

  // Unpack the input item
  assign action          = spq_action_t'(in_tdata[1:0]);
  assign new_entry.id    = in_tdata[17:2];
  assign new_entry.zone  = in_tdata[25:18];
  assign new_entry.value = in_tdata[57:26];
  assign new_entry.prio  = in_tdata[65:58];

  // Accept while the result register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Decode the step command for the chain
  always_comb begin
    ctl       = '0;
    status    = ST_OK;
    count_nxt = count_r;
    if (in_fire) begin
      unique case (action)
        ACT_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.rem   = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        ACT_CLEAR: begin
          ctl.clr   = 1'b1;
          count_nxt = '0;
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  // Row of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t prev_entry;
    logic       prev_valid;
    logic       prev_gt;
    spq_entry_t next_entry;
    logic       next_valid;

    if (i == 0) begin : g_first
      assign prev_entry = new_entry;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = cell_entry[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = cell_entry[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
      assign next_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_entry (prev_entry),
      .prev_valid (prev_valid),
      .prev_gt    (prev_gt),
      .next_entry (next_entry),
      .next_valid (next_valid),
      .entry      (cell_entry[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .entry_nxt  (cell_entry_nxt[i]),
      .valid_nxt  (cell_valid_nxt[i])
    );
  end

  // Front entry leaves on remove; front after the step comes from cell 0
  assign removed = ctl.rem ? cell_entry[0] : '0;
  assign head    = cell_valid_nxt[0] ? cell_entry_nxt[0] : '0;

  // Pack the result item
  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[1:0]     = status;
    out_data_nxt[2]       = ctl.rem;
    out_data_nxt[18:3]    = removed.id;
    out_data_nxt[26:19]   = removed.zone;
    out_data_nxt[58:27]   = removed.value;
    out_data_nxt[66:59]   = removed.prio;
    out_data_nxt[82:67]   = head.id;
    out_data_nxt[90:83]   = head.zone;
    out_data_nxt[122:91]  = head.value;
    out_data_nxt[130:123] = head.prio;
    out_data_nxt[135:131] = OUT_CNT_W'(count_nxt);
    out_data_nxt[136]     = (count_nxt == '0);
  end

  // Hold count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Valid cells always form a solid run from the front
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("cell valid bits not contiguous from the front");

  // Count matches the number of valid cells
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(count_r))
    else $error("count disagrees with cell valid bits");

  // A remove from a non-empty queue drops the count by one
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not decrement the count");

  // The front is never served after a later cell
  a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("front entries out of priority order");
`endif

endmodule

/* design/spq_cell.sv */
// One cell of the sorted chain: holds an entry and its valid bit.
// Depends on spq_pkg; instantiated in a row by stable_priority_queue_core.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  spq_ctl_t   ctl,
  input  spq_entry_t new_entry,
  input  spq_entry_t prev_entry,
  input  logic       prev_valid,
  input  logic       prev_gt,
  input  spq_entry_t next_entry,
  input  logic       next_valid,
  output spq_entry_t entry,
  output logic       valid,
  output logic       gt,
  output spq_entry_t entry_nxt,
  output logic       valid_nxt
);

  spq_entry_t entry_r;
  logic       valid_r;

  // Stored entry is served after the new one
  assign gt = valid_r && (entry_r.prio > new_entry.prio);

  // Pick the next content: shift right on insert, shift left on remove, empty on clear
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      valid_nxt = valid_r | prev_valid;
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || !valid_r) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.rem) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Hold the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule
